// ===== rtl/p2sca_pkg.sv =====
// ============================================================================
// p2sca_pkg
// Shared types and constants for the power-of-two size-class allocator.
// ============================================================================
package p2sca_pkg;

  localparam int unsigned DefAddrBits   = 32;
  localparam int unsigned DefNumClasses = 32;
  localparam int unsigned DefStackDepth = 256;
  localparam int unsigned DefFreshClass = 20;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_HEAP_BASE  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_HEAP_LIMIT = 1'b1;

  localparam logic [4:0] MIN_CLASS = 5'd4;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOHEAP = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_SPLIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        op;
    logic [30:0] req_size;
    logic [31:0] block_addr;
    logic [4:0]  block_class;
  } req_t;

  typedef struct packed {
    logic [31:0] addr_out;
    logic [4:0]  class_out;
    logic [1:0]  status;
  } rsp_t;

  // Round a request up to its class: bit length of size-1, at least MIN_CLASS.
  function automatic logic [4:0] size_class(input logic [30:0] size);
    logic [30:0] v;
    logic [4:0]  c;
    v = size - 31'd1;
    c = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (v[i]) c = 5'(i + 1);
    end
    if (size <= 31'd16) c = MIN_CLASS;
    return c;
  endfunction

endpackage

// ===== rtl/p2sca_stack_mem.sv =====
// ============================================================================
// p2sca_stack_mem
// Free-list storage: one flat memory, one write and one registered read port.
// ============================================================================
module p2sca_stack_mem
  import p2sca_pkg::*;
#(
  parameter int unsigned AW = 13,
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write and read in one clocked block
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pow2_size_class_allocator.sv =====
// ============================================================================
// pow2_size_class_allocator
// Power-of-two size-class allocator that splits blocks but never merges them.
// ============================================================================
// Usage:
//   in_*  : request channel (valid/ready), payload req_t: op 0 allocates
//           req_size bytes, op 1 frees block_addr onto class block_class.
//   out_* : result channel (valid/ready), payload rsp_t, one per request.
//   cfg_* : register writes, index 0 heap_base (also reloads the bump
//           pointer), index 1 heap_limit. Write only while idle.
// Timing:
//   A free's result is valid in the cycle after it is accepted. An allocate
//   walks upward one class per cycle looking for a non-empty list or a fresh
//   carve, reads a popped entry in S_READ, then splits downward one class
//   per cycle with one free-list memory write each while that list has room.
//   The single write port sets the split pace.
//   One request is in flight at a time; in_ready returns the cycle after the
//   result is taken, so a stalled receiver holds the result and blocks input.
// Reset:
//   rst_n clears all list counts, heap_base to 0, heap_limit to all ones
//   and the bump pointer to heap_base. List memory needs no clearing.
// ============================================================================
module pow2_size_class_allocator
  import p2sca_pkg::*;
#(
  parameter int unsigned ADDR_BITS   = DefAddrBits,
  parameter int unsigned NUM_CLASSES = DefNumClasses,
  parameter int unsigned STACK_DEPTH = DefStackDepth,
  parameter int unsigned FRESH_CLASS = DefFreshClass
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  req_t               in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rsp_t               out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int unsigned CW  = $clog2(NUM_CLASSES);
  localparam int unsigned SW  = $clog2(STACK_DEPTH);
  localparam int unsigned NW  = SW + 1;
  localparam int unsigned MAW = CW + SW;

  state_t        state_r, state_nxt;
  logic [NW-1:0] cnt_r [NUM_CLASSES];
  logic [32:0]   bump_r, bump_nxt;
  logic [31:0]   base_r, base_nxt;
  logic [31:0]   limit_r;
  logic [6:0]    cls_r, cls_nxt;    // class being visited
  logic [6:0]    tgt_r, tgt_nxt;    // requested class
  logic [32:0]   blk_r, blk_nxt;    // found block base
  rsp_t          rsp_r, rsp_nxt;

  logic          mem_we;
  logic [MAW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;

  logic          cnt_inc, cnt_dec;
  logic [CW-1:0] cnt_sel;

  logic [CW-1:0]  cur;
  logic [NW-1:0]  cur_cnt;
  logic [33:0]    end_w, chunk;
  logic [4:0]     req_cls;
  logic [CW-1:0]  fcls;
  logic           fcls_ok;

  assign cur     = cls_r[CW-1:0];
  assign cur_cnt = cnt_r[cur];
  assign end_w   = {2'b0, limit_r} + 34'd1;
  assign chunk   = 34'd1 << cls_r;
  assign req_cls = size_class(in_data.req_size);
  assign fcls    = CW'(in_data.block_class);
  assign fcls_ok = {2'b0, in_data.block_class} < 7'(NUM_CLASSES);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data  = rsp_r;

  p2sca_stack_mem #(.AW(MAW), .DW(32)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer: next state, datapath and memory controls
  always_comb begin
    state_nxt = state_r;
    bump_nxt  = bump_r;
    cls_nxt   = cls_r;
    tgt_nxt   = tgt_r;
    blk_nxt   = blk_r;
    rsp_nxt   = rsp_r;
    mem_we    = 1'b0;
    mem_waddr = {cur, cur_cnt[SW-1:0]};
    mem_wdata = '0;
    mem_raddr = {cur, cur_cnt[SW-1:0] - SW'(1)};
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    cnt_sel   = cur;
    base_nxt  = base_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rsp_nxt = '{addr_out: '0, class_out: '0, status: ST_OK};
          if (in_data.op) begin
            cnt_sel = fcls;
            if (!fcls_ok || cnt_r[fcls] >= NW'(STACK_DEPTH)) begin
              rsp_nxt.status = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = {fcls, cnt_r[fcls][SW-1:0]};
              mem_wdata = in_data.block_addr & 32'((64'd1 << ADDR_BITS) - 1);
              cnt_inc   = 1'b1;
            end
            state_nxt = S_DONE;
          end else begin
            cls_nxt   = {2'b0, req_cls};
            tgt_nxt   = {2'b0, req_cls};
            state_nxt = S_SEARCH;
          end
        end
      end
      // Walk upward one class per cycle
      S_SEARCH: begin
        if (cls_r >= 7'(NUM_CLASSES)) begin
          rsp_nxt.status = ST_NOHEAP;
          state_nxt = S_DONE;
        end else if (cur_cnt != '0) begin
          cnt_dec   = 1'b1;
          state_nxt = S_READ;
        end else if (cls_r > tgt_r && cls_r >= 7'(FRESH_CLASS)) begin
          // A chunk above 2^32 never fits the address space
          if (cls_r > 7'd32 || {1'b0, bump_r} > end_w ||
              end_w - {1'b0, bump_r} < chunk) begin
            rsp_nxt.status = ST_NOHEAP;
            state_nxt = S_DONE;
          end else begin
            blk_nxt   = bump_r;
            bump_nxt  = 33'({1'b0, bump_r} + chunk);
            state_nxt = S_SPLIT;
          end
        end else begin
          cls_nxt = cls_r + 7'd1;
        end
      end
      // Popped entry lands from the registered read port
      S_READ: begin
        blk_nxt   = {1'b0, mem_rdata};
        state_nxt = S_SPLIT;
      end
      // Push one upper half per class passed while its list has room
      S_SPLIT: begin
        if (cls_r > tgt_r) begin
          cnt_sel   = CW'(cls_r - 7'd1);
          mem_waddr = {cnt_sel, cnt_r[cnt_sel][SW-1:0]};
          mem_wdata = 32'(blk_r + (33'd1 << (cls_r - 7'd1)));
          if (cnt_r[cnt_sel] < NW'(STACK_DEPTH)) begin
            mem_we  = 1'b1;
            cnt_inc = 1'b1;
          end
          cls_nxt = cls_r - 7'd1;
        end else begin
          rsp_nxt.addr_out  = 32'(blk_r) & 32'((64'd1 << ADDR_BITS) - 1);
          rsp_nxt.class_out = tgt_r[4:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we && cfg_index == CFG_HEAP_BASE) begin
      base_nxt = cfg_wdata;
      bump_nxt = {1'b0, cfg_wdata};
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bump_r  <= '0;
      base_r  <= '0;
      limit_r <= '1;
      for (int i = 0; i < NUM_CLASSES; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      bump_r  <= bump_nxt;
      base_r  <= base_nxt;
      if (cfg_we && cfg_index == CFG_HEAP_LIMIT) limit_r <= cfg_wdata;
      if (cnt_inc) cnt_r[cnt_sel] <= cnt_r[cnt_sel] + NW'(1);
      else if (cnt_dec) cnt_r[cnt_sel] <= cnt_r[cnt_sel] - NW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cls_r <= cls_nxt;
    tgt_r <= tgt_nxt;
    blk_r <= blk_nxt;
    rsp_r <= rsp_nxt;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Checks the power-of-two size-class allocator. Requests go in through a directed
// table, overflow and tight-heap cases, then random allocate/free traffic, with
// random idling on both channels. A predictor tracks the free lists and the bump
// pointer and works out each result; results are compared against a queue of expectations.
// ============================================================================
module tb_top;
  import p2sca_pkg::*;

  localparam int NCLS  = 32;
  localparam int DEPTH = 256;
  localparam int FRESH = 20;
  localparam int WATCHDOG_LIMIT = 20000;

  // One row of the directed table. When has_exp is set the predicted result
  // is also compared with the typed-in value.
  typedef struct {
    req_t  req;
    bit    has_exp;
    rsp_t  exp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_data;
  logic        cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_HEAP_BASE;
  logic [31:0] cfg_wdata = '0;

  // Predictor state
  logic [31:0] lists [NCLS][DEPTH];
  int          list_cnt [NCLS];
  logic [32:0] bump;
  logic [31:0] base_reg;
  logic [31:0] limit_reg;

  rsp_t        rsp_q [$];
  int          errors = 0;
  int          idle_in_pct = 0;
  int          stall_out_pct = 0;
  int          quiet_cycles = 0;
  bit          req_done = 1'b0;
  dir_row_t    dir_tbl [$];

  pow2_size_class_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic [4:0] round_class(logic [30:0] size);
    logic [30:0] v;
    logic [4:0]  c;
    c = 5'd0;
    if (size <= 31'd16) return MIN_CLASS;
    v = size - 31'd1;
    while (v != 0) begin
      c++;
      v = v >> 1;
    end
    return c;
  endfunction

  // Compute the result of one request and update the free lists.
  function automatic rsp_t predict_alloc(req_t r);
    rsp_t  o;
    int    c;
    int    cb;
    bit    found;
    logic [32:0] blk;
    logic [32:0] sz;
    logic [32:0] lim_end;
    o = '{addr_out: '0, class_out: '0, status: ST_OK};
    found = 1'b0;
    blk = '0;
    if (r.op) begin
      if (list_cnt[r.block_class] >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        lists[r.block_class][list_cnt[r.block_class]] = r.block_addr;
        list_cnt[r.block_class]++;
      end
      return o;
    end
    c = round_class(r.req_size);
    cb = c;
    if (list_cnt[c] > 0) begin
      list_cnt[c]--;
      blk = {1'b0, lists[c][list_cnt[c]]};
    end else begin
      while (!found) begin
        cb++;
        if (cb >= NCLS) break;
        if (list_cnt[cb] > 0) begin
          list_cnt[cb]--;
          blk = {1'b0, lists[cb][list_cnt[cb]]};
          found = 1'b1;
        end else if (cb >= FRESH) begin
          sz = 33'd1 << cb;
          lim_end = {1'b0, limit_reg} + 33'd1;
          if (bump > lim_end || lim_end - bump < sz) break;
          blk = bump;
          bump = bump + sz;
          found = 1'b1;
        end
      end
      if (!found) begin
        o.status = ST_NOHEAP;
        return o;
      end
    end
    // Split down, pushing each upper half that its list has room for
    while (cb > c) begin
      cb--;
      if (list_cnt[cb] < DEPTH) begin
        lists[cb][list_cnt[cb]] = 32'(blk + (33'd1 << cb));
        list_cnt[cb]++;
      end
    end
    o.addr_out = blk[31:0];
    o.class_out = 5'(c);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Write one register, then idle with the write enable low before returning.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HEAP_BASE) begin
      base_reg = val;
      bump = {1'b0, val};
    end else begin
      limit_reg = val;
    end
    @(posedge clk);
  endtask

  // Send one request, honoring the idle rate; valid stays high between items when no idling is drawn.
  task automatic send_request(req_t r, bit has_exp, rsp_t exp);
    rsp_t p;
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    p = predict_alloc(r);
    if (has_exp && p != exp) begin
      report_mismatch("table row", {25'd0, p.class_out, p.status}, {25'd0, exp.class_out, exp.status});
    end
    rsp_q.push_back(p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic req_t mk_alloc(logic [30:0] size);
    req_t r;
    r = '0;
    r.req_size = size;
    r.block_addr = $urandom;
    r.block_class = 5'($urandom);
    return r;
  endfunction

  function automatic req_t mk_free(logic [31:0] a, logic [4:0] cls);
    req_t r;
    r.op = 1'b1;
    r.req_size = 31'($urandom);
    r.block_addr = a;
    r.block_class = cls;
    return r;
  endfunction

  // Random request: mostly small allocations and frees back to live classes.
  function automatic req_t rand_request();
    int k;
    k = $urandom_range(99);
    if (k < 45) return mk_alloc(31'($urandom_range(1 << $urandom_range(16, 4))));
    if (k < 50) return mk_alloc(31'($urandom));
    if (k < 90) return mk_free($urandom, 5'($urandom_range(19, 4)));
    return mk_free($urandom, 5'($urandom));
  endfunction

  // Receiver with random stalls; compare in order.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (rsp_q.size() == 0) begin
          report_mismatch("unexpected result", out_data.addr_out, 32'd0);
        end else begin
          want = rsp_q.pop_front();
          if (out_data.addr_out != want.addr_out)
            report_mismatch("addr_out", out_data.addr_out, want.addr_out);
          if (out_data.class_out != want.class_out)
            report_mismatch("class_out", 32'(out_data.class_out), 32'(want.class_out));
          if (out_data.status != want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
        end
      end
      out_ready <= ($urandom_range(99) >= stall_out_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || req_done)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL pow2_size_class_allocator");
      $finish;
    end
  end

  initial begin
    rsp_t z;
    rsp_t heap_err;
    rsp_t full_err;
    for (int i = 0; i < NCLS; i++) list_cnt[i] = 0;
    base_reg = '0;
    limit_reg = '1;
    bump = '0;
    z = '{addr_out: '0, class_out: '0, status: ST_OK};
    heap_err = '{addr_out: '0, class_out: '0, status: ST_NOHEAP};
    full_err = '{addr_out: '0, class_out: '0, status: ST_FULL};

    // Directed table
    dir_tbl.push_back('{mk_alloc(31'd0), 1'b1,
                        '{addr_out: 32'h0, class_out: 5'd4, status: ST_OK}});
    dir_tbl.push_back('{mk_alloc(31'd9), 1'b0, z});
    dir_tbl.push_back('{mk_alloc(31'd16), 1'b0, z});
    dir_tbl.push_back('{mk_alloc(31'd17), 1'b0, z});
    dir_tbl.push_back('{mk_alloc(31'h7FFF_FFFF), 1'b1, heap_err});
    dir_tbl.push_back('{mk_alloc(31'h4000_0000), 1'b0, z});
    dir_tbl.push_back('{mk_alloc(31'h4000_0001), 1'b0, z});
    dir_tbl.push_back('{mk_free(32'hFFFF_FFFF, 5'd31), 1'b1, z});
    dir_tbl.push_back('{mk_free(32'h0, 5'd4), 1'b1, z});
    dir_tbl.push_back('{mk_alloc(31'd5), 1'b1,
                        '{addr_out: 32'h0, class_out: 5'd4, status: ST_OK}});
    dir_tbl.push_back('{mk_free(32'hA5A5_5A5A, 5'd0), 1'b1, z});
    dir_tbl.push_back('{mk_alloc(31'd1 << 30), 1'b0, z});
    dir_tbl.push_back('{mk_alloc(31'd1000), 1'b0, z});
    dir_tbl.push_back('{mk_free(32'h1234_5678, 5'd12), 1'b1, z});
    dir_tbl.push_back('{mk_alloc(31'd4096), 1'b0, z});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) send_request(dir_tbl[i].req, dir_tbl[i].has_exp, dir_tbl[i].exp);
    drain();

    // Fill one list to overflow
    for (int i = 0; i < DEPTH; i++) send_request(mk_free($urandom, 5'd7), 1'b0, z);
    send_request(mk_free(32'h0, 5'd7), 1'b1, full_err);
    drain();

    // Tight heap: base near the top, small limit window
    write_reg(CFG_HEAP_BASE, 32'hFFE0_0000);
    write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    send_request(mk_alloc(31'd1 << 22), 1'b1, heap_err);
    for (int i = 0; i < 6; i++) send_request(mk_alloc(31'd1 << 20), 1'b0, z);
    drain();
    write_reg(CFG_HEAP_LIMIT, 32'h0);
    send_request(mk_alloc(31'd1 << 25), 1'b1, heap_err);
    drain();

    // Random phases with different idling and heap settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
        1: begin idle_in_pct = 52; stall_out_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_out_pct = 52; end
        default: begin idle_in_pct = 14; stall_out_pct = 14; end
      endcase
      write_reg(CFG_HEAP_BASE, (ph == 3) ? 32'h0 : $urandom & 32'hFFF0_0000);
      write_reg(CFG_HEAP_LIMIT, (ph == 0) ? 32'hFFFF_FFFF : $urandom);
      for (int i = 0; i < 195; i++) send_request(rand_request(), 1'b0, z);
      drain();
    end

    req_done = 1'b1;
    if (errors == 0) begin
      $display("PASS pow2_size_class_allocator");
    end else begin
      $display("FAIL pow2_size_class_allocator");
    end
    $finish;
  end

endmodule

// ===== pow2_size_class_allocator.f =====
rtl/p2sca_pkg.sv
rtl/p2sca_stack_mem.sv
rtl/pow2_size_class_allocator.sv
tb/sv/tb_top.sv
